// ===== hw/rtl/lvm_pkg.sv =====
package lvm_pkg;

    localparam int FRAC_BITS = 16;
    localparam int UW = FRAC_BITS + 2;   // unit vector component, signed
    localparam int QW = FRAC_BITS + 1;   // quotient magnitude bits
    localparam int NW = 31 + FRAC_BITS;  // divider numerator
    localparam int AW = 33;              // multiplier A operand, signed
    localparam int PW = AW + UW;         // product
    localparam int VW = 64;              // accumulator / raw vector component

    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] upward_x;
        logic signed [31:0] upward_y;
        logic signed [31:0] upward_z;
    } lvm_in_t;

    typedef struct packed {
        logic [1:0]         column_index;
        logic signed [31:0] elem_row0;
        logic signed [31:0] elem_row1;
        logic signed [31:0] elem_row2;
        logic signed [31:0] elem_row3;
        logic               degenerate;
        logic               last_column;
    } lvm_out_t;

    typedef struct packed {
        logic [2:0][31:0] eye;
        logic [2:0][32:0] dif;
        logic [2:0][31:0] up;
        logic             degen;
    } lvm_entry_t;

    typedef struct packed {
        logic             start;
        logic [2:0][VW-1:0] vin;
    } lvm_ureq_t;

    typedef struct packed {
        logic             done;
        logic [2:0][UW-1:0] vout;
    } lvm_ursp_t;

endpackage

// ===== hw/rtl/lookat_view_matrix.sv =====
// Look-at view matrix generator. Each input beat carries eye, target and up
// vectors in signed fixed point (FRAC_BITS fraction bits, Q16.16 by default);
// the block returns the column-major 4x4 view matrix as four output beats,
// columns 0 to 3, with last_column set on column 3. Columns 0..2 hold the
// x, y and z axis components with a zero fourth row; column 3 holds the
// negated, rounded and saturated dot products of each axis with the eye,
// and 1.0 in row 3. When eye equals target all axes and the translation are
// zero and degenerate is set on every beat of that matrix.
// The shared normalizing unit is used three times per item: a one-bit-per-cycle
// shift search, three squares, a 32-step square root and a (FRAC_BITS+1)-step
// divider. The multiply-accumulate runs on the single shared multiplier, and an
// all-zero axis skips its normalization. A two-deep queue takes new items while
// the back end is busy, and the output register holds each column until it is
// taken; the back end loads the next column only once the register is free.
module lookat_view_matrix import lvm_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  lvm_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output lvm_out_t m_data
);

    logic       q_full;
    logic       q_push;
    lvm_entry_t q_entry;
    logic       q_valid;
    lvm_entry_t q_head;
    logic       q_pop;
    lvm_ureq_t  ureq;
    lvm_ursp_t  ursp;

    // Front: accept beats, form eye - target, flag the degenerate case.
    lvm_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_entry)
    );

    // Hold up to two classified items between front and back.
    lvm_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .entry_in (q_entry),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .head     (q_head),
        .full     (q_full)
    );

    // Shared normalizer: shift search, sum of squares, square root, divide.
    lvm_unit u_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ureq),
        .rsp     (ursp)
    );

    // Back: sequence the normalizations, cross products and translation,
    // then advance the four columns into the output register.
    lvm_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .ureq    (ureq),
        .ursp    (ursp),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== hw/rtl/lvm_front.sv =====
module lvm_front import lvm_pkg::*; (
    input  logic       s_valid,
    output logic       s_ready,
    input  lvm_in_t    s_data,
    input  logic       q_full,
    output logic       q_push,
    output lvm_entry_t q_entry
);

    logic [2:0][31:0] eye;
    logic [2:0][31:0] tgt;

    // Element 0 holds x, element 2 holds z.
    assign eye = {s_data.eye_z, s_data.eye_y, s_data.eye_x};
    assign tgt = {s_data.target_z, s_data.target_y, s_data.target_x};

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Form the view direction and flag eye == target up front.
    always_comb begin
        q_entry.eye   = eye;
        q_entry.up    = {s_data.upward_z, s_data.upward_y, s_data.upward_x};
        q_entry.degen = (eye == tgt);
        for (int i = 0; i < 3; i++) begin
            q_entry.dif[i] = {eye[i][31], eye[i]} - {tgt[i][31], tgt[i]};
        end
    end

endmodule

// ===== hw/rtl/lvm_queue.sv =====
module lvm_queue import lvm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  lvm_entry_t entry_in,
    input  logic       pop,
    output logic       q_valid,
    output lvm_entry_t head,
    output logic       full
);

    lvm_entry_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign q_valid = (cnt_reg != 2'd0);
    assign full    = (cnt_reg == 2'd2);
    assign head    = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= entry_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

// ===== hw/rtl/lvm_unit.sv =====
module lvm_unit import lvm_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  lvm_ureq_t req,
    output lvm_ursp_t rsp
);

    localparam logic [2:0] U_IDLE = 3'd0;
    localparam logic [2:0] U_NORM = 3'd1;
    localparam logic [2:0] U_SQ   = 3'd2;
    localparam logic [2:0] U_SQRT = 3'd3;
    localparam logic [2:0] U_DSET = 3'd4;
    localparam logic [2:0] U_DIV  = 3'd5;
    localparam logic [2:0] U_SIGN = 3'd6;
    localparam logic [2:0] U_DONE = 3'd7;

    logic [2:0]         state_reg;
    logic [5:0]         cnt_reg;
    logic [2:0][VW-1:0] mag_reg;
    logic [2:0]         neg_reg;
    logic [59:0]        sq_reg;
    logic [61:0]        sum_reg;
    logic [63:0]        n_reg;
    logic [63:0]        r_reg;
    logic [63:0]        bit_reg;
    logic [31:0]        len_reg;
    logic [2:0][31:0]   rem_reg;
    logic [2:0][QW-1:0] low_reg;
    logic [2:0][QW-1:0] q_reg;
    logic [2:0][UW-1:0] vout_reg;

    logic [2:0][VW-1:0] abs_in;
    logic               zero_in;
    logic               over;
    logic               in_band;
    logic [63:0]        trial;
    logic               take;
    logic [2:0][32:0]   dt;
    logic [2:0]         dge;
    logic [2:0][NW-1:0] num;

    always_comb begin
        over    = 1'b0;
        in_band = 1'b0;
        for (int i = 0; i < 3; i++) begin
            abs_in[i] = req.vin[i][VW-1] ? (VW'(0) - req.vin[i]) : req.vin[i];
            over      = over | (|mag_reg[i][VW-1:30]);
            in_band   = in_band | mag_reg[i][29];
            dt[i]     = {rem_reg[i], low_reg[i][QW-1]};
            dge[i]    = (dt[i] >= {1'b0, len_reg});
            num[i]    = {1'b0, mag_reg[i][29:0], {FRAC_BITS{1'b0}}} + NW'(r_reg[31:1]);
        end
        zero_in = (req.vin == '0);
        trial   = r_reg + bit_reg;
        take    = (n_reg >= trial);
    end

    assign rsp.done = (state_reg == U_DONE);
    assign rsp.vout = vout_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
            cnt_reg   <= '0;
        end else begin
            case (state_reg)
                U_IDLE: begin
                    if (req.start) begin
                        mag_reg <= abs_in;
                        for (int i = 0; i < 3; i++) begin
                            neg_reg[i] <= req.vin[i][VW-1];
                        end
                        if (zero_in) begin
                            vout_reg  <= '0;
                            state_reg <= U_DONE;
                        end else begin
                            state_reg <= U_NORM;
                        end
                    end
                end
                U_NORM: begin
                    // Bring the largest magnitude into [2^29, 2^30).
                    if (over) begin
                        for (int i = 0; i < 3; i++) begin
                            mag_reg[i] <= mag_reg[i] >> 1;
                        end
                    end else if (!in_band) begin
                        for (int i = 0; i < 3; i++) begin
                            mag_reg[i] <= mag_reg[i] << 1;
                        end
                    end else begin
                        cnt_reg   <= '0;
                        sum_reg   <= '0;
                        state_reg <= U_SQ;
                    end
                end
                U_SQ: begin
                    if (cnt_reg != 6'd3) begin
                        sq_reg <= mag_reg[cnt_reg[1:0]][29:0] * mag_reg[cnt_reg[1:0]][29:0];
                    end
                    if (cnt_reg == 6'd3) begin
                        n_reg     <= 64'(sum_reg) + 64'(sq_reg);
                        r_reg     <= '0;
                        bit_reg   <= 64'(1) << 62;
                        cnt_reg   <= '0;
                        state_reg <= U_SQRT;
                    end else begin
                        if (cnt_reg != 6'd0) begin
                            sum_reg <= sum_reg + 62'(sq_reg);
                        end
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                U_SQRT: begin
                    if (take) begin
                        n_reg <= n_reg - trial;
                        r_reg <= (r_reg >> 1) + bit_reg;
                    end else begin
                        r_reg <= r_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd31) begin
                        state_reg <= U_DSET;
                    end
                end
                U_DSET: begin
                    // Round to nearest: add half the length before dividing.
                    len_reg <= r_reg[31:0];
                    for (int i = 0; i < 3; i++) begin
                        rem_reg[i] <= 32'(num[i][NW-1:QW]);
                        low_reg[i] <= num[i][QW-1:0];
                        q_reg[i]   <= '0;
                    end
                    cnt_reg   <= '0;
                    state_reg <= U_DIV;
                end
                U_DIV: begin
                    for (int i = 0; i < 3; i++) begin
                        rem_reg[i] <= dge[i] ? 32'(dt[i] - {1'b0, len_reg}) : dt[i][31:0];
                        low_reg[i] <= low_reg[i] << 1;
                        q_reg[i]   <= {q_reg[i][QW-2:0], dge[i]};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(QW - 1)) begin
                        state_reg <= U_SIGN;
                    end
                end
                U_SIGN: begin
                    for (int i = 0; i < 3; i++) begin
                        vout_reg[i] <= neg_reg[i] ? (UW'(0) - {1'b0, q_reg[i]})
                                                  : {1'b0, q_reg[i]};
                    end
                    state_reg <= U_DONE;
                end
                U_DONE: begin
                    state_reg <= U_IDLE;
                end
                default: begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/lvm_back.sv =====
module lvm_back import lvm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  lvm_entry_t q_head,
    output logic       q_pop,
    output lvm_ureq_t  ureq,
    input  lvm_ursp_t  ursp,
    output logic       m_valid,
    input  logic       m_ready,
    output lvm_out_t   m_data
);

    localparam logic [3:0] B_IDLE = 4'd0;
    localparam logic [3:0] B_UZ   = 4'd1;
    localparam logic [3:0] B_CX   = 4'd2;
    localparam logic [3:0] B_SX   = 4'd3;
    localparam logic [3:0] B_UX   = 4'd4;
    localparam logic [3:0] B_CY   = 4'd5;
    localparam logic [3:0] B_SY   = 4'd6;
    localparam logic [3:0] B_UY   = 4'd7;
    localparam logic [3:0] B_TR   = 4'd8;
    localparam logic [3:0] B_TF   = 4'd9;
    localparam logic [3:0] B_EM   = 4'd10;

    localparam logic signed [VW-1:0] HALF    = VW'(1) << (FRAC_BITS - 1);
    localparam logic signed [VW-1:0] SAT_MAX = VW'(32'h7fff_ffff);
    localparam logic signed [VW-1:0] SAT_MIN = -(VW'(1) << 31);
    localparam logic [31:0]          ONE_Q   = 32'(1) << FRAC_BITS;

    function automatic logic [1:0] nxt3(input logic [1:0] i);
        logic [1:0] r;
        case (i)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    logic [3:0]             state_reg;
    logic [2:0][31:0]       eye_reg;
    logic [2:0][31:0]       up_reg;
    logic                   degen_reg;
    logic [2:0][UW-1:0]     az_reg;
    logic [2:0][UW-1:0]     ax_reg;
    logic [2:0][UW-1:0]     ay_reg;
    logic [2:0][VW-1:0]     acc_reg;
    logic signed [PW-1:0]   prod_reg;
    logic [1:0]             dst_reg;
    logic [1:0]             term_reg;
    logic                   ph_reg;
    logic [2:0][31:0]       trans_reg;
    logic [1:0]             col_reg;
    logic                   m_valid_reg;
    lvm_out_t               m_data_reg;

    logic [1:0]             ia;
    logic [1:0]             ib;
    logic                   sub;
    logic [1:0]             last_term;
    logic signed [AW-1:0]   op_a;
    logic signed [UW-1:0]   op_b;
    logic [VW-1:0]          prod_ext;
    logic                   out_free;
    lvm_out_t               col_data;
    logic signed [VW-1:0]   tsum [3];
    logic signed [VW-1:0]   tsh  [3];

    // Operand pick for the shared multiplier.
    always_comb begin
        last_term = (state_reg == B_TR) ? 2'd2 : 2'd1;
        if (state_reg == B_TR) begin
            ia  = term_reg;
            ib  = term_reg;
            sub = 1'b0;
        end else if (term_reg == 2'd0) begin
            ia  = nxt3(dst_reg);
            ib  = nxt3(nxt3(dst_reg));
            sub = 1'b0;
        end else begin
            ia  = nxt3(nxt3(dst_reg));
            ib  = nxt3(dst_reg);
            sub = 1'b1;
        end
        case (state_reg)
            B_CX: begin
                op_a = {up_reg[ia][31], up_reg[ia]};
                op_b = az_reg[ib];
            end
            B_CY: begin
                op_a = {{(AW-UW){az_reg[ia][UW-1]}}, az_reg[ia]};
                op_b = ax_reg[ib];
            end
            default: begin
                op_a = {eye_reg[ia][31], eye_reg[ia]};
                case (dst_reg)
                    2'd0:    op_b = ax_reg[ib];
                    2'd1:    op_b = ay_reg[ib];
                    default: op_b = az_reg[ib];
                endcase
            end
        endcase
        prod_ext = {{(VW-PW){prod_reg[PW-1]}}, prod_reg};
    end

    // Negate, round half up at the binary point, clamp to 32 bits.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            tsum[k] = HALF - $signed(acc_reg[k]);
            tsh[k]  = tsum[k] >>> FRAC_BITS;
        end
    end

    always_comb begin
        ureq.start = ((state_reg == B_IDLE) && q_valid) || (state_reg == B_SX)
                     || (state_reg == B_SY);
        for (int i = 0; i < 3; i++) begin
            ureq.vin[i] = (state_reg == B_IDLE)
                          ? {{(VW-33){q_head.dif[i][32]}}, q_head.dif[i]} : acc_reg[i];
        end
    end

    assign q_pop = (state_reg == B_IDLE) && q_valid;

    always_comb begin
        col_data.column_index = col_reg;
        col_data.degenerate   = degen_reg;
        col_data.last_column  = (col_reg == 2'd3);
        if (col_reg == 2'd3) begin
            col_data.elem_row0 = trans_reg[0];
            col_data.elem_row1 = trans_reg[1];
            col_data.elem_row2 = trans_reg[2];
            col_data.elem_row3 = ONE_Q;
        end else begin
            col_data.elem_row0 = {{(32-UW){ax_reg[col_reg][UW-1]}}, ax_reg[col_reg]};
            col_data.elem_row1 = {{(32-UW){ay_reg[col_reg][UW-1]}}, ay_reg[col_reg]};
            col_data.elem_row2 = {{(32-UW){az_reg[col_reg][UW-1]}}, az_reg[col_reg]};
            col_data.elem_row3 = '0;
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
            dst_reg     <= '0;
            term_reg    <= '0;
            ph_reg      <= 1'b0;
            col_reg     <= '0;
        end else begin
            // Drop valid once the beat is taken, unless B_EM loads the next one.
            if (m_valid_reg && m_ready && (state_reg != B_EM)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE: begin
                    if (q_valid) begin
                        eye_reg   <= q_head.eye;
                        up_reg    <= q_head.up;
                        degen_reg <= q_head.degen;
                        state_reg <= B_UZ;
                    end
                end
                B_UZ, B_UX, B_UY: begin
                    if (ursp.done) begin
                        acc_reg  <= '0;
                        dst_reg  <= '0;
                        term_reg <= '0;
                        ph_reg   <= 1'b0;
                        case (state_reg)
                            B_UZ: begin
                                az_reg    <= ursp.vout;
                                state_reg <= B_CX;
                            end
                            B_UX: begin
                                ax_reg    <= ursp.vout;
                                state_reg <= B_CY;
                            end
                            default: begin
                                ay_reg    <= ursp.vout;
                                state_reg <= B_TR;
                            end
                        endcase
                    end
                end
                B_CX, B_CY, B_TR: begin
                    if (!ph_reg) begin
                        prod_reg <= op_a * op_b;
                        ph_reg   <= 1'b1;
                    end else begin
                        acc_reg[dst_reg] <= sub ? (acc_reg[dst_reg] - prod_ext)
                                                : (acc_reg[dst_reg] + prod_ext);
                        ph_reg <= 1'b0;
                        if (term_reg == last_term) begin
                            term_reg <= '0;
                            if (dst_reg == 2'd2) begin
                                dst_reg <= '0;
                                case (state_reg)
                                    B_CX:    state_reg <= B_SX;
                                    B_CY:    state_reg <= B_SY;
                                    default: state_reg <= B_TF;
                                endcase
                            end else begin
                                dst_reg <= dst_reg + 2'd1;
                            end
                        end else begin
                            term_reg <= term_reg + 2'd1;
                        end
                    end
                end
                B_SX: begin
                    state_reg <= B_UX;
                end
                B_SY: begin
                    state_reg <= B_UY;
                end
                B_TF: begin
                    for (int k = 0; k < 3; k++) begin
                        if (tsh[k] > SAT_MAX) begin
                            trans_reg[k] <= 32'h7fff_ffff;
                        end else if (tsh[k] < SAT_MIN) begin
                            trans_reg[k] <= 32'h8000_0000;
                        end else begin
                            trans_reg[k] <= tsh[k][31:0];
                        end
                    end
                    col_reg   <= '0;
                    state_reg <= B_EM;
                end
                B_EM: begin
                    if (out_free) begin
                        m_data_reg  <= col_data;
                        m_valid_reg <= 1'b1;
                        col_reg     <= col_reg + 2'd1;
                        if (col_reg == 2'd3) begin
                            state_reg <= B_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/lvm_checker.sv =====
module lvm_checker import lvm_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     m_valid,
    input logic     m_ready,
    input lvm_out_t m_data
);

    localparam logic [31:0] ONE_Q = 32'(1) << FRAC_BITS;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat dropped or changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last_column == (m_data.column_index == 2'd3)))
        else $error("last_column does not match column index");

    a_row3: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.column_index == 2'd3) ? (m_data.elem_row3 == ONE_Q)
                                                   : (m_data.elem_row3 == '0)))
        else $error("row 3 element wrong");

    a_degen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |-> m_data.elem_row0 == '0
            && m_data.elem_row1 == '0 && m_data.elem_row2 == '0)
        else $error("degenerate matrix has nonzero elements");

endmodule

bind lookat_view_matrix lvm_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== verif/tb_lookat_view_matrix.sv =====
module tb_lookat_view_matrix;
    import lvm_pkg::*;

    // Scoreboard: turn each accepted input beat into its four expected
    // column beats, then check result beats against them in order.
    class lookat_scoreboard;
        lvm_out_t expected_columns[$];
        int       mismatches;

        function automatic logic [63:0] isqrt_floor(logic [63:0] n);
            logic [63:0] root;
            logic [63:0] bitpos;
            root = 0;
            bitpos = 64'd1 << 62;
            while (bitpos > n) bitpos = bitpos >> 2;
            while (bitpos != 0) begin
                if (n >= root + bitpos) begin
                    n = n - (root + bitpos);
                    root = (root >> 1) + bitpos;
                end else begin
                    root = root >> 1;
                end
                bitpos = bitpos >> 2;
            end
            return root;
        endfunction

        // Scale magnitudes into [2^29, 2^30), then round each component
        // against the floor square root of the sum of squares.
        function automatic void normalize_axis(input longint v[3], output longint u[3]);
            logic [63:0] mag[3];
            logic [63:0] big;
            logic [63:0] len;
            logic [63:0] quo;
            big = 0;
            for (int i = 0; i < 3; i++) begin
                mag[i] = v[i] < 0 ? -v[i] : v[i];
                if (mag[i] > big) big = mag[i];
            end
            if (big == 0) begin
                for (int i = 0; i < 3; i++) u[i] = 0;
                return;
            end
            while (big >= (64'd1 << 30)) begin
                big = big >> 1;
                for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
            end
            while (big < (64'd1 << 29)) begin
                big = big << 1;
                for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
            end
            len = isqrt_floor(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
            for (int i = 0; i < 3; i++) begin
                quo = ((mag[i] << FRAC_BITS) + (len >> 1)) / len;
                u[i] = v[i] < 0 ? -longint'(quo) : longint'(quo);
            end
        endfunction

        function automatic logic signed [31:0] translation(longint a[3], longint e[3]);
            longint      t;
            logic [63:0] biased;
            longint      r;
            t = -(a[0] * e[0] + a[1] * e[1] + a[2] * e[2]);
            biased = t + (64'd1 << 60) + (64'd1 << (FRAC_BITS - 1));
            r = longint'(biased >> FRAC_BITS) - longint'(64'd1 << (60 - FRAC_BITS));
            if (r > 64'sd2147483647) r = 64'sd2147483647;
            if (r < -64'sd2147483648) r = -64'sd2147483648;
            return r[31:0];
        endfunction

        function void note_input(lvm_in_t in);
            longint   eye[3], tgt[3], up[3], dif[3], crs[3];
            longint   ax[3], ay[3], az[3];
            lvm_out_t col;
            logic     degen;
            eye = '{in.eye_x, in.eye_y, in.eye_z};
            tgt = '{in.target_x, in.target_y, in.target_z};
            up  = '{in.upward_x, in.upward_y, in.upward_z};
            for (int i = 0; i < 3; i++) dif[i] = eye[i] - tgt[i];
            degen = (dif[0] == 0 && dif[1] == 0 && dif[2] == 0);
            normalize_axis(dif, az);
            crs[0] = up[1] * az[2] - up[2] * az[1];
            crs[1] = up[2] * az[0] - up[0] * az[2];
            crs[2] = up[0] * az[1] - up[1] * az[0];
            normalize_axis(crs, ax);
            crs[0] = az[1] * ax[2] - az[2] * ax[1];
            crs[1] = az[2] * ax[0] - az[0] * ax[2];
            crs[2] = az[0] * ax[1] - az[1] * ax[0];
            normalize_axis(crs, ay);
            for (int c = 0; c < 3; c++) begin
                col.column_index = 2'(c);
                col.elem_row0 = ax[c][31:0];
                col.elem_row1 = ay[c][31:0];
                col.elem_row2 = az[c][31:0];
                col.elem_row3 = '0;
                col.degenerate = degen;
                col.last_column = 1'b0;
                expected_columns.push_back(col);
            end
            col.column_index = 2'd3;
            col.elem_row0 = translation(ax, eye);
            col.elem_row1 = translation(ay, eye);
            col.elem_row2 = translation(az, eye);
            col.elem_row3 = 32'sd1 << FRAC_BITS;
            col.degenerate = degen;
            col.last_column = 1'b1;
            expected_columns.push_back(col);
        endfunction

        function void check_result(lvm_out_t got);
            lvm_out_t want;
            if (expected_columns.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected column beat %p", got);
                return;
            end
            want = expected_columns.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) $display("column mismatch: expected %p actual %p", want, got);
            end
        endfunction
    endclass

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    lvm_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    lvm_out_t m_data;

    lookat_scoreboard scoreboard = new();
    bit       calm_phase = 1'b0;   // no idling on either side while set
    longint   cycle_count = 0;
    localparam longint CYCLE_LIMIT = 4_000_000;

    lookat_view_matrix dut (.*);

    always #4 aclk = ~aclk;

    // Abort if the run hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Check every result beat; the sampled value precedes this edge's updates.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) scoreboard.check_result(m_data);
    end

    // Result side: stall a random number of cycles before each beat.
    initial begin
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            stall = calm_phase ? 0 : $urandom_range(0, 12);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk iff m_valid);
        end
    end

    // Present one beat, hold it until accepted, and note it on acceptance.
    // Valid stays high into the next beat when there is no gap.
    task automatic send_beat(lvm_in_t beat);
        int gap;
        gap = calm_phase ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data  <= beat;
        s_valid <= 1'b1;
        @(posedge aclk iff s_ready);
        scoreboard.note_input(beat);
    endtask

    function automatic logic signed [31:0] random_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            2: return $signed($urandom_range(0, 32)) - 16;
            3: return 32'sh7fffffff - $urandom_range(0, 3);
            4: return 32'sh80000000 + $urandom_range(0, 3);
            default: return ($signed($urandom_range(0, 200)) - 100) <<< FRAC_BITS;
        endcase
    endfunction

    initial begin
        lvm_in_t beat;
        localparam logic signed [31:0] ONE = 32'sd1 << FRAC_BITS;
        localparam logic signed [31:0] MAXV = 32'sh7fffffff;
        localparam logic signed [31:0] MINV = 32'sh80000000;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: canonical camera, eye equals target, up parallel to the
        // view axis, zero up, and field extremes.
        send_beat('{0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0});
        send_beat('{3 * ONE, -2 * ONE, ONE, 3 * ONE, -2 * ONE, ONE, 0, ONE, 0});
        send_beat('{0, 0, 0, 0, 0, 0, 0, 0, 0});
        send_beat('{0, 0, ONE, 0, 0, 0, 0, 0, ONE});
        send_beat('{0, 0, ONE, 0, 0, 0, 0, 0, 0});
        send_beat('{MAXV, MAXV, MAXV, MINV, MINV, MINV, MAXV, MINV, MAXV});
        send_beat('{MINV, MINV, MINV, MAXV, MAXV, MAXV, MINV, MAXV, MINV});
        send_beat('{MAXV, MINV, MAXV, 0, 0, 0, MINV, MINV, MINV});
        send_beat('{MINV, MAXV, 0, MAXV, MINV, 0, 0, 0, MAXV});
        send_beat('{1, 0, 0, 0, 0, 0, 0, 1, 0});
        send_beat('{-1, -1, -1, 0, 0, 0, -1, 1, -1});
        send_beat('{MAXV, MAXV, MAXV, MAXV - 1, MAXV, MAXV, 0, 1, 0});
        send_beat('{-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, 1, 1, 1});

        // Random: a calm stretch first, then idling on both sides.
        calm_phase = 1'b1;
        for (int n = 0; n < 450; n++) begin
            if (n == 40) calm_phase = 1'b0;
            beat.eye_x = random_coord();
            beat.eye_y = random_coord();
            beat.eye_z = random_coord();
            if ($urandom_range(0, 19) == 0) begin
                beat.target_x = beat.eye_x;
                beat.target_y = beat.eye_y;
                beat.target_z = beat.eye_z;
            end else begin
                beat.target_x = random_coord();
                beat.target_y = random_coord();
                beat.target_z = random_coord();
            end
            beat.upward_x = random_coord();
            beat.upward_y = random_coord();
            beat.upward_z = random_coord();
            send_beat(beat);
        end
        s_valid <= 1'b0;

        while (scoreboard.expected_columns.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (scoreboard.mismatches == 0 && scoreboard.expected_columns.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
